// ===== rtl/core/rps_pkg.sv =====
// Shared types and codes for the ratio priority sorter.
// Holds item structs, op codes and the per-cell control struct; no dependencies.
package rps_pkg;

   localparam int FIELD_W = 16;
   localparam int NUM_W   = 8;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef struct packed {
      logic               op;
      logic [FIELD_W-1:0] duration;
      logic [FIELD_W-1:0] fine_rate;
   } req_type;

   typedef struct packed {
      logic [NUM_W-1:0] job_number;
      logic             last_of_run;
      logic             store_empty;
      logic             overflow_seen;
   } rsp_type;

   typedef struct packed {
      logic mult_en;
      logic insert_en;
      logic shift_en;
   } rps_ctrl_type;

endpackage

// ===== rtl/core/rps_cell.sv =====
// One slot of the sorted job chain: holds a job and its cross products.
// Depends on rps_pkg for the control struct and number width.
module rps_cell import rps_pkg::*; #(
   parameter int MAX_JOBS   = 128,
   parameter int VALUE_BITS = 16,
   parameter int INDEX      = 0
) (
   input  logic                           clock,
   input  rps_ctrl_type                   ctrl,
   input  logic [$clog2(MAX_JOBS+1)-1:0]  count,
   input  logic [VALUE_BITS-1:0]          new_dur,
   input  logic [VALUE_BITS-1:0]          new_fine,
   input  logic [NUM_W-1:0]               new_num,
   input  logic                           left_higher,
   input  logic [VALUE_BITS-1:0]          left_dur,
   input  logic [VALUE_BITS-1:0]          left_fine,
   input  logic [NUM_W-1:0]               left_num,
   input  logic [VALUE_BITS-1:0]          right_dur,
   input  logic [VALUE_BITS-1:0]          right_fine,
   input  logic [NUM_W-1:0]               right_num,
   output logic                           higher,
   output logic [VALUE_BITS-1:0]          dur,
   output logic [VALUE_BITS-1:0]          fine,
   output logic [NUM_W-1:0]               num
);

   localparam int CNT_W  = $clog2(MAX_JOBS+1);
   localparam int PROD_W = 2*VALUE_BITS;

   logic [VALUE_BITS-1:0] dur_ff, dur_in;
   logic [VALUE_BITS-1:0] fine_ff, fine_in;
   logic [NUM_W-1:0]      num_ff, num_in;
   logic [PROD_W-1:0]     prod_new_ff, prod_new_in;
   logic [PROD_W-1:0]     prod_own_ff, prod_own_in;
   logic                  occupied;

   assign occupied = (count > CNT_W'(INDEX));

   // new job beats this slot when the slot is empty or strictly lower ratio
   assign higher = !occupied || (prod_new_ff > prod_own_ff);

   assign prod_new_in = ctrl.mult_en ? PROD_W'(new_fine) * PROD_W'(dur_ff) : prod_new_ff;
   assign prod_own_in = ctrl.mult_en ? PROD_W'(fine_ff) * PROD_W'(new_dur) : prod_own_ff;

   always_comb begin
      dur_in  = dur_ff;
      fine_in = fine_ff;
      num_in  = num_ff;
      if (ctrl.insert_en && higher) begin
         if (left_higher) begin
            // move the left job down one slot
            dur_in  = left_dur;
            fine_in = left_fine;
            num_in  = left_num;
         end else begin
            dur_in  = new_dur;
            fine_in = new_fine;
            num_in  = new_num;
         end
      end else if (ctrl.shift_en) begin
         dur_in  = right_dur;
         fine_in = right_fine;
         num_in  = right_num;
      end
   end

   always_ff @(posedge clock) begin
      dur_ff      <= dur_in;
      fine_ff     <= fine_in;
      num_ff      <= num_in;
      prod_new_ff <= prod_new_in;
      prod_own_ff <= prod_own_in;
   end

   assign dur  = dur_ff;
   assign fine = fine_ff;
   assign num  = num_ff;

endmodule

// ===== rtl/core/ratio_priority_sorter.sv =====
// Channel  | Dir | Payload   | Handshake
// req_     | in  | req_type  | req_valid / req_ready
// rsp_     | out | rsp_type  | rsp_valid / rsp_ready
//
// A drain completes in the accepting state; a load steps through accept, cross
// multiply in every cell, then compare and insert, as each cell registers its products.
// A load into a full store only sets the sticky flag.
// Reset clears the job count, numbering and flag; cell contents stay unknown.
// Any item is held off while an unread result sits in the output register
// and rsp_ready is low.
// Top level of the ratio priority sorter; uses rps_pkg and rps_cell.
module ratio_priority_sorter import rps_pkg::*; #(
   parameter int MAX_JOBS   = 128,
   parameter int VALUE_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int CNT_W = $clog2(MAX_JOBS+1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_MULT   = 2'd1;
   localparam logic [1:0] ST_INSERT = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [NUM_W-1:0]      next_num_ff, next_num_in;
   logic                  ovf_ff, ovf_in;
   logic [VALUE_BITS-1:0] cand_dur_ff, cand_dur_in;
   logic [VALUE_BITS-1:0] cand_fine_ff, cand_fine_in;
   logic [NUM_W-1:0]      cand_num_ff, cand_num_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic [VALUE_BITS-1:0] dur_raw;
   logic [VALUE_BITS-1:0] fine_raw;
   rps_ctrl_type          ctrl;

   logic                  higher_w [MAX_JOBS];
   logic [VALUE_BITS-1:0] dur_w    [MAX_JOBS];
   logic [VALUE_BITS-1:0] fine_w   [MAX_JOBS];
   logic [NUM_W-1:0]      num_w    [MAX_JOBS];

   generate
      if (VALUE_BITS <= FIELD_W) begin : g_narrow
         assign dur_raw  = req_data.duration[VALUE_BITS-1:0];
         assign fine_raw = req_data.fine_rate[VALUE_BITS-1:0];
      end else begin : g_wide
         assign dur_raw  = {{(VALUE_BITS-FIELD_W){1'b0}}, req_data.duration};
         assign fine_raw = {{(VALUE_BITS-FIELD_W){1'b0}}, req_data.fine_rate};
      end
   endgenerate

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      next_num_in   = next_num_ff;
      ovf_in        = ovf_ff;
      cand_dur_in   = cand_dur_ff;
      cand_fine_in  = cand_fine_ff;
      cand_num_in   = cand_num_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      ctrl.mult_en  = 1'b0;
      ctrl.insert_en = 1'b0;
      ctrl.shift_en = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.op == OP_LOAD) begin
                  if (count_ff == CNT_W'(MAX_JOBS)) begin
                     // drop the job, keep its number
                     ovf_in = 1'b1;
                  end else begin
                     cand_dur_in  = (dur_raw == '0) ? VALUE_BITS'(1) : dur_raw;
                     cand_fine_in = fine_raw;
                     cand_num_in  = next_num_ff;
                     next_num_in  = next_num_ff + NUM_W'(1);
                     state_in     = ST_MULT;
                  end
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in.overflow_seen = ovf_ff;
                  if (count_ff == '0) begin
                     rsp_data_in.job_number  = '0;
                     rsp_data_in.last_of_run = 1'b0;
                     rsp_data_in.store_empty = 1'b1;
                     next_num_in = NUM_W'(1);
                  end else begin
                     rsp_data_in.job_number  = num_w[0];
                     rsp_data_in.last_of_run = (count_ff == CNT_W'(1));
                     rsp_data_in.store_empty = 1'b0;
                     count_in      = count_ff - CNT_W'(1);
                     ctrl.shift_en = 1'b1;
                     if (count_ff == CNT_W'(1)) begin
                        next_num_in = NUM_W'(1);
                     end
                  end
               end
            end
         end
         ST_MULT: begin
            ctrl.mult_en = 1'b1;
            state_in     = ST_INSERT;
         end
         ST_INSERT: begin
            ctrl.insert_en = 1'b1;
            count_in       = count_ff + CNT_W'(1);
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         next_num_ff  <= NUM_W'(1);
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         next_num_ff  <= next_num_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_dur_ff  <= cand_dur_in;
      cand_fine_ff <= cand_fine_in;
      cand_num_ff  <= cand_num_in;
      rsp_data_ff  <= rsp_data_in;
   end

   generate
      for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
         logic                  left_higher;
         logic [VALUE_BITS-1:0] left_dur, left_fine, right_dur, right_fine;
         logic [NUM_W-1:0]      left_num, right_num;

         if (i == 0) begin : g_head
            assign left_higher = 1'b0;
            assign left_dur    = '0;
            assign left_fine   = '0;
            assign left_num    = '0;
         end else begin : g_body
            assign left_higher = higher_w[i-1];
            assign left_dur    = dur_w[i-1];
            assign left_fine   = fine_w[i-1];
            assign left_num    = num_w[i-1];
         end

         if (i == MAX_JOBS-1) begin : g_tail
            assign right_dur  = '0;
            assign right_fine = '0;
            assign right_num  = '0;
         end else begin : g_next
            assign right_dur  = dur_w[i+1];
            assign right_fine = fine_w[i+1];
            assign right_num  = num_w[i+1];
         end

         rps_cell #(
            .MAX_JOBS   (MAX_JOBS),
            .VALUE_BITS (VALUE_BITS),
            .INDEX      (i)
         ) u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .count       (count_ff),
            .new_dur     (cand_dur_ff),
            .new_fine    (cand_fine_ff),
            .new_num     (cand_num_ff),
            .left_higher (left_higher),
            .left_dur    (left_dur),
            .left_fine   (left_fine),
            .left_num    (left_num),
            .right_dur   (right_dur),
            .right_fine  (right_fine),
            .right_num   (right_num),
            .higher      (higher_w[i]),
            .dur         (dur_w[i]),
            .fine        (fine_w[i]),
            .num         (num_w[i])
         );
      end
   endgenerate

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
